// ===== src/grmc_pkg.sv =====
// Shared types, constants and coefficient tables of the Gaussian running mean classifier.
// No dependencies.
package grmc_pkg;

  localparam int NUM_MEAN_REGS = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int DATA_W        = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MEAN0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SIGMA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd5;

  localparam logic [DATA_W-1:0] INV_SIGMA_RESET = 16'd8192;
  localparam logic [DATA_W-1:0] THRESHOLD_RESET = 16'd49152;
  localparam logic [DATA_W-1:0] COUNT_MAX       = 16'hFFFF;

  localparam int X_W    = 18;
  localparam int DEN_W  = 18;
  localparam int T_W    = 17;
  localparam int PACC_W = 21;
  localparam int PMAG_W = 20;
  localparam int F_W    = 30;
  localparam int E_W    = 31;
  localparam int K_W    = 4;

  localparam logic [31:0] INV_SQRT2_Q16 = 32'd46341;
  localparam logic [31:0] P_Q16         = 32'd21469;
  localparam logic [E_W-1:0] Q30_ONE    = 31'h4000_0000;

  localparam logic signed [PACC_W-1:0] POLY_C0 = 21'sd69560;

  localparam logic [K_W-1:0] HORNER_STEPS  = 4'd5;
  localparam logic [K_W-1:0] TAYLOR_TERMS  = 4'd12;
  localparam logic [K_W-1:0] EXP_SQUARINGS = 4'd4;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_Z, OP_XS, OP_X, OP_PX, OP_DEN, OP_T, OP_HMUL, OP_HADD,
    OP_SQ, OP_F, OP_TM1, OP_TV, OP_TM2, OP_TQ, OP_TC, OP_EM, OP_ES, OP_PM, OP_P,
    OP_AM, OP_AD, OP_AW, OP_FIN
  } grmc_op_t;

  typedef struct packed {
    grmc_op_t       op;
    logic [K_W-1:0] k;
  } grmc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic far;
  } grmc_stat_t;

  function automatic logic [DATA_W-1:0] mean_reset(input int i);
    case (i)
      0:       mean_reset = 16'd12534;
      1:       mean_reset = 16'd14172;
      2:       mean_reset = 16'd11223;
      3:       mean_reset = 16'd7946;
      default: mean_reset = '0;
    endcase
  endfunction

  // Horner coefficients after the leading one; the final step adds nothing
  function automatic logic signed [PACC_W-1:0] poly_coef(input logic [K_W-1:0] k);
    case (k)
      4'd1:    poly_coef = -21'sd95234;
      4'd2:    poly_coef = 21'sd93154;
      4'd3:    poly_coef = -21'sd18645;
      4'd4:    poly_coef = 21'sd16701;
      default: poly_coef = '0;
    endcase
  endfunction

  // floor(2^30 / k)
  function automatic logic [E_W-1:0] recip_q30(input logic [K_W-1:0] k);
    case (k)
      4'd1:    recip_q30 = 31'd1073741824;
      4'd2:    recip_q30 = 31'd536870912;
      4'd3:    recip_q30 = 31'd357913941;
      4'd4:    recip_q30 = 31'd268435456;
      4'd5:    recip_q30 = 31'd214748364;
      4'd6:    recip_q30 = 31'd178956970;
      4'd7:    recip_q30 = 31'd153391689;
      4'd8:    recip_q30 = 31'd134217728;
      4'd9:    recip_q30 = 31'd119304647;
      4'd10:   recip_q30 = 31'd107374182;
      4'd11:   recip_q30 = 31'd97612893;
      4'd12:   recip_q30 = 31'd89478485;
      default: recip_q30 = '0;
    endcase
  endfunction

endpackage

// ===== src/grmc_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// No dependencies.
module grmc_div #(
  parameter int DW = 33,
  parameter int VW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CNW = $clog2(DW + 1);

  logic [DW-1:0]  quo_r;
  logic [VW-1:0]  rem_r;
  logic [VW-1:0]  dvs_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [VW:0]    rem_sh;
  logic [VW:0]    rem_dif;
  logic           ge;

  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign rem_dif = rem_sh - {1'b0, dvs_r};
  assign ge      = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? rem_dif[VW-1:0] : rem_sh[VW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/grmc_dpath.sv =====
// Datapath: configuration registers, shared multiplier, divider, class averages, result register.
// Depends on grmc_pkg and grmc_div.
module grmc_dpath #(
  parameter int NUM_CLASSES = 4,
  parameter int PROB_BITS   = 16,
  parameter int CW          = 2,
  parameter int DW          = 33
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  grmc_pkg::grmc_cmd_t               cmd,
  input  logic [CW-1:0]                     cls,
  output grmc_pkg::grmc_stat_t              st,
  input  logic [grmc_pkg::DATA_W-1:0]       in_peak_reading,
  input  logic                              cfg_valid,
  input  logic [grmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [grmc_pkg::DATA_W-1:0]       cfg_data,
  output logic                              out_decided,
  output logic [1:0]                        out_best_class,
  output logic [15:0]                       out_best_probability,
  output logic [2:0]                        out_latched_class
);
  import grmc_pkg::*;

  localparam int LW = $clog2(NUM_CLASSES + 1);
  localparam logic [PROB_BITS-1:0] PROB_MAX = '1;

  logic [DATA_W-1:0]   mean_r [NUM_MEAN_REGS];
  logic [DATA_W-1:0]   mean_v [NUM_CLASSES];
  logic [DATA_W-1:0]   isig_r;
  logic [DATA_W-1:0]   thr_r;
  logic [PROB_BITS-1:0] avg_r [NUM_CLASSES];
  logic [DATA_W-1:0]   count_r;
  logic [LW-1:0]       dec_r;

  logic [DATA_W-1:0]   reading_r;
  logic [63:0]         prod_r;
  logic [X_W-1:0]      x_r;
  logic                far_r;
  logic [T_W-1:0]      t_r;
  logic signed [PACC_W-1:0] pacc_r;
  logic [F_W-1:0]      f_r;
  logic [E_W-1:0]      eacc_r;
  logic [F_W-1:0]      v_r;
  logic [F_W-1:0]      q_r;
  logic [PROB_BITS-1:0] p_r;
  logic [PROB_BITS-1:0] best_r;
  logic [CW-1:0]       bidx_r;

  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [DATA_W-1:0]   mean_sel;
  logic [DATA_W-1:0]   abs_diff;
  logic [63:0]         xw;
  logic [DEN_W-1:0]    den;
  logic [PMAG_W-1:0]   pmag;
  logic [PMAG_W-1:0]   pclamp;
  logic [63:0]         hmag;
  logic signed [PACC_W-1:0] hval;
  logic [F_W+K_W-1:0]  trem;
  logic [F_W-1:0]      tq;
  logic [63:0]         pw;
  logic [DATA_W:0]     n1;
  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  logic                div_done;
  logic [DW-1:0]       div_quo;
  logic [PROB_BITS-1:0] qa;
  logic [DATA_W+24:0]  thr_w;
  logic                decided;

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_mean
    assign mean_v[g] = (g < NUM_MEAN_REGS) ? mean_r[g % NUM_MEAN_REGS] : '0;
  end

  assign mean_sel = mean_v[cls];
  assign abs_diff = (reading_r >= mean_sel) ? reading_r - mean_sel : mean_sel - reading_r;
  assign xw       = (prod_r + 64'h80_0000) >> 24;
  assign den      = DEN_W'(64'd65536 + ((prod_r + 64'd32768) >> 16));
  assign pmag     = pacc_r[PACC_W-1] ? PMAG_W'(-pacc_r) : PMAG_W'(pacc_r);
  assign pclamp   = pacc_r[PACC_W-1] ? '0 : PMAG_W'(pacc_r);
  assign hmag     = (prod_r + 64'd32768) >> 16;
  assign hval     = pacc_r[PACC_W-1] ? -$signed(PACC_W'(hmag)) : $signed(PACC_W'(hmag));
  assign trem     = {{K_W{1'b0}}, v_r} - q_r * cmd.k;
  assign tq       = (trem >= (F_W+K_W)'(cmd.k)) ? q_r + 1'b1 : q_r;
  assign pw       = (prod_r + (64'd1 << (45 - PROB_BITS))) >> (46 - PROB_BITS);
  assign n1       = {1'b0, count_r} + 1'b1;
  assign qa       = div_quo[PROB_BITS-1:0];
  assign thr_w    = ({25'd0, thr_r} << PROB_BITS) >> 16;
  assign decided  = (DATA_W+25)'(best_r) >= thr_w;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_Z: begin
        mul_a = 32'(abs_diff);
        mul_b = 32'(isig_r);
      end
      OP_XS: begin
        mul_a = prod_r[31:0];
        mul_b = INV_SQRT2_Q16;
      end
      OP_PX: begin
        mul_a = 32'(x_r);
        mul_b = P_Q16;
      end
      OP_HMUL: begin
        mul_a = 32'(pmag);
        mul_b = 32'(t_r);
      end
      OP_SQ: begin
        mul_a = 32'(x_r);
        mul_b = 32'(x_r);
      end
      OP_TM1: begin
        mul_a = 32'(f_r);
        mul_b = 32'(eacc_r);
      end
      OP_TM2: begin
        mul_a = 32'(v_r);
        mul_b = 32'(recip_q30(cmd.k));
      end
      OP_EM: begin
        mul_a = 32'(eacc_r);
        mul_b = 32'(eacc_r);
      end
      OP_PM: begin
        mul_a = 32'(pclamp);
        mul_b = 32'(eacc_r);
      end
      OP_AM: begin
        mul_a = 32'(count_r);
        mul_b = 32'(avg_r[cls]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start    = (cmd.op == OP_DEN) || (cmd.op == OP_AD);
  assign div_dividend = (cmd.op == OP_DEN) ? DW'((64'd1 << 32) + 64'(den >> 1))
                                           : DW'(prod_r + 64'(p_r) + 64'(n1 >> 1));
  assign div_divisor  = (cmd.op == OP_DEN) ? den : DEN_W'(n1);

  grmc_div #(
    .DW (DW),
    .VW (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MEAN_REGS; i++) begin
        mean_r[i] <= mean_reset(i);
      end
      for (int i = 0; i < NUM_CLASSES; i++) begin
        avg_r[i] <= '0;
      end
      isig_r  <= INV_SIGMA_RESET;
      thr_r   <= THRESHOLD_RESET;
      count_r <= '0;
      dec_r   <= LW'(NUM_CLASSES);
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_INV_SIGMA) begin
          isig_r <= cfg_data;
        end else if (cfg_index == REG_THRESHOLD) begin
          thr_r <= cfg_data;
        end else begin
          for (int i = 0; i < NUM_MEAN_REGS; i++) begin
            if (i < NUM_CLASSES && cfg_index == REG_MEAN0 + CFG_IDX_W'(i)) begin
              mean_r[i] <= cfg_data;
            end
          end
        end
      end
      if (cmd.op == OP_AW) begin
        avg_r[cls] <= qa;
      end
      if (cmd.op == OP_FIN) begin
        if (count_r != COUNT_MAX) begin
          count_r <= count_r + 1'b1;
        end
        if (decided) begin
          dec_r <= LW'(bidx_r);
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: reading_r <= in_peak_reading;
      OP_X: begin
        x_r   <= xw[X_W-1:0];
        far_r <= xw >= (64'd1 << X_W);
        p_r   <= '0;
      end
      OP_T: begin
        t_r    <= div_quo[T_W-1:0];
        pacc_r <= POLY_C0;
      end
      OP_HADD: pacc_r <= hval + poly_coef(cmd.k);
      OP_F: begin
        f_r    <= F_W'(((prod_r + 64'd32768) >> 16) << 10);
        eacc_r <= Q30_ONE;
      end
      OP_TV: v_r <= F_W'(prod_r >> 30);
      OP_TQ: q_r <= F_W'(prod_r >> 30);
      OP_TC: eacc_r <= Q30_ONE - E_W'(tq);
      OP_ES: eacc_r <= E_W'((prod_r + 64'h2000_0000) >> 30);
      OP_P:  p_r <= (pw > 64'(PROB_MAX)) ? PROB_MAX : PROB_BITS'(pw);
      OP_AW: begin
        if (cls == '0 || qa > best_r) begin
          best_r <= qa;
          bidx_r <= cls;
        end
      end
      OP_FIN: begin
        out_decided          <= decided;
        out_best_class       <= 2'(bidx_r);
        out_best_probability <= 16'(best_r);
        out_latched_class    <= decided ? 3'(bidx_r) : 3'(dec_r);
      end
      default: begin
      end
    endcase
  end

  assign st.div_done = div_done;
  assign st.far      = far_r;

endmodule

// ===== src/grmc_ctrl.sv =====
// Controller: sequences the per-class steps and owns the channel handshakes.
// Depends on grmc_pkg.
module grmc_ctrl #(
  parameter int NUM_CLASSES = 4,
  parameter int CW          = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  grmc_pkg::grmc_stat_t st,
  output grmc_pkg::grmc_cmd_t  cmd,
  output logic [CW-1:0]        cls
);
  import grmc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_Z, S_XS, S_X, S_PX, S_DEN, S_DWAIT, S_T, S_HMUL, S_HADD, S_SQ, S_F,
    S_TM1, S_TV, S_TM2, S_TQ, S_TC, S_EM, S_ES, S_PM, S_P, S_AM, S_AD, S_AWAIT,
    S_AW, S_FIN
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  cls_r;
  logic [K_W-1:0] k_r;
  logic           out_valid_r;
  logic           slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    case (state_r)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NOP;
      S_Z:     cmd.op = OP_Z;
      S_XS:    cmd.op = OP_XS;
      S_X:     cmd.op = OP_X;
      S_PX:    cmd.op = OP_PX;
      S_DEN:   cmd.op = OP_DEN;
      S_T:     cmd.op = OP_T;
      S_HMUL:  cmd.op = OP_HMUL;
      S_HADD:  cmd.op = OP_HADD;
      S_SQ:    cmd.op = OP_SQ;
      S_F:     cmd.op = OP_F;
      S_TM1:   cmd.op = OP_TM1;
      S_TV:    cmd.op = OP_TV;
      S_TM2:   cmd.op = OP_TM2;
      S_TQ:    cmd.op = OP_TQ;
      S_TC:    cmd.op = OP_TC;
      S_EM:    cmd.op = OP_EM;
      S_ES:    cmd.op = OP_ES;
      S_PM:    cmd.op = OP_PM;
      S_P:     cmd.op = OP_P;
      S_AM:    cmd.op = OP_AM;
      S_AD:    cmd.op = OP_AD;
      S_AW:    cmd.op = OP_AW;
      S_FIN:   cmd.op = slot_free ? OP_FIN : OP_NOP;
      default: cmd.op = OP_NOP;
    endcase
    cmd.k = k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cls_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_Z;
            cls_r   <= '0;
          end
        end
        S_Z:   state_r <= S_XS;
        S_XS:  state_r <= S_X;
        S_X:   state_r <= S_PX;
        S_PX:  state_r <= st.far ? S_AM : S_DEN;
        S_DEN: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (st.div_done) begin
            state_r <= S_T;
          end
        end
        S_T: begin
          state_r <= S_HMUL;
          k_r     <= 4'd1;
        end
        S_HMUL: state_r <= S_HADD;
        S_HADD: begin
          if (k_r == HORNER_STEPS) begin
            state_r <= S_SQ;
          end else begin
            state_r <= S_HMUL;
            k_r     <= k_r + 1'b1;
          end
        end
        S_SQ: state_r <= S_F;
        S_F: begin
          state_r <= S_TM1;
          k_r     <= TAYLOR_TERMS;
        end
        S_TM1: state_r <= S_TV;
        S_TV:  state_r <= S_TM2;
        S_TM2: state_r <= S_TQ;
        S_TQ:  state_r <= S_TC;
        S_TC: begin
          if (k_r == 4'd1) begin
            state_r <= S_EM;
            k_r     <= '0;
          end else begin
            state_r <= S_TM1;
            k_r     <= k_r - 1'b1;
          end
        end
        S_EM: state_r <= S_ES;
        S_ES: begin
          if (k_r == EXP_SQUARINGS - 1'b1) begin
            state_r <= S_PM;
          end else begin
            state_r <= S_EM;
            k_r     <= k_r + 1'b1;
          end
        end
        S_PM: state_r <= S_P;
        S_P:  state_r <= S_AM;
        S_AM: state_r <= S_AD;
        S_AD: state_r <= S_AWAIT;
        S_AWAIT: begin
          if (st.div_done) begin
            state_r <= S_AW;
          end
        end
        S_AW: begin
          if (cls_r == CW'(NUM_CLASSES - 1)) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_Z;
            cls_r   <= cls_r + 1'b1;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cls       = cls_r;

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("result committed over an untaken result");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == S_DWAIT || state_r == S_AWAIT))
    else $error("divider finished outside a wait state");

  a_taylor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TC) |-> (k_r >= 4'd1 && k_r <= TAYLOR_TERMS))
    else $error("Taylor term index out of range");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    cls_r <= CW'(NUM_CLASSES - 1))
    else $error("class index out of range");

endmodule

// ===== src/gaussian_running_mean_classifier_top.sv =====
// Gaussian likelihood classifier with per-class running mean of tail probabilities.
// One item at a time: one new reading is taken only after the previous one has been fully
// processed. Each class runs through the shared multiplier and the DW-bit restoring divider
// (DW = max(33, PROB_BITS+17)); a class in the far tail (x >= 4) skips to the average update
// with a zero probability. The result sits in an output register, so the next reading is
// taken while it waits. cfg_ready is always high.
module gaussian_running_mean_classifier_top #(
  parameter int NUM_CLASSES = 4,
  parameter int PROB_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [grmc_pkg::DATA_W-1:0]    in_peak_reading,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_decided,
  output logic [1:0]                     out_best_class,
  output logic [15:0]                    out_best_probability,
  output logic [2:0]                     out_latched_class,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [grmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grmc_pkg::DATA_W-1:0]    cfg_data
);
  import grmc_pkg::*;

  localparam int CW = $clog2(NUM_CLASSES);
  localparam int DW = (PROB_BITS + 17 > 33) ? PROB_BITS + 17 : 33;

  grmc_cmd_t     cmd;
  grmc_stat_t    st;
  logic [CW-1:0] cls;

  assign cfg_ready = 1'b1;

  grmc_ctrl #(
    .NUM_CLASSES (NUM_CLASSES),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd),
    .cls       (cls)
  );

  grmc_dpath #(
    .NUM_CLASSES (NUM_CLASSES),
    .PROB_BITS   (PROB_BITS),
    .CW          (CW),
    .DW          (DW)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cls                  (cls),
    .st                   (st),
    .in_peak_reading      (in_peak_reading),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_decided          (out_decided),
    .out_best_class       (out_best_class),
    .out_best_probability (out_best_probability),
    .out_latched_class    (out_latched_class)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for gaussian_running_mean_classifier_top: a clocked driver and monitor,
// a built-in Gaussian tail probability and running mean predictor, and random stall bursts.
// Depends on grmc_pkg and the top-level RTL.
`timescale 1ns / 100ps

module testbench;
  import grmc_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    bit        decided;
    bit [1:0]  best_cls;
    bit [15:0] best_prob;
    bit [2:0]  latched;
  } verdict_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_peak_reading;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_decided;
  logic [1:0]           out_best_class;
  logic [15:0]          out_best_probability;
  logic [2:0]           out_latched_class;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  gaussian_running_mean_classifier_top DUT (.*);

  // classifier model state
  bit [15:0]   class_mean[4];
  bit [15:0]   inv_sigma;
  bit [15:0]   threshold;
  int unsigned class_avg[4];
  int unsigned reading_cnt;
  bit [2:0]    latched_cls;

  bit [15:0] reading_q[$];
  verdict_t  verdict_q[$];
  int        errors;
  bit        quiet;
  int        in_gap;
  int        out_gap;
  longint    cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint qmul(longint a, longint unsigned t);
    longint unsigned mag;
    if (a < 0) begin
      mag = (longint'(-a) * t + 32768) >> 16;
      return -longint'(mag);
    end
    mag = (longint'(a) * t + 32768) >> 16;
    return longint'(mag);
  endfunction

  function automatic int unsigned tail_prob(bit [15:0] rd, bit [15:0] mu, bit [15:0] isig);
    longint unsigned d, z, x, den, t, s, f, e, prob;
    longint acc;
    longint hc[5] = '{69560, -95234, 93154, -18645, 16701};
    d = (rd >= mu) ? longint'(rd - mu) : longint'(mu - rd);
    z = d * isig;
    x = (z * 46341 + (64'd1 << 23)) >> 24;
    if (x >= (64'd4 << 16)) return 0;
    den = 65536 + ((21469 * x + 32768) >> 16);
    t = ((64'd1 << 32) + (den >> 1)) / den;
    acc = hc[0];
    for (int k = 1; k < 5; k++) acc = qmul(acc, t) + hc[k];
    acc = qmul(acc, t);
    if (acc < 0) acc = 0;
    s = (x * x + 32768) >> 16;
    f = s << 10;
    e = 64'd1 << 30;
    for (int n = 12; n >= 1; n--) e = (64'd1 << 30) - ((f * e) >> 30) / n;
    for (int n = 0; n < 4; n++) e = (e * e + (64'd1 << 29)) >> 30;
    prob = (longint'(acc) * e + (64'd1 << 29)) >> 30;
    return (prob > 65535) ? 65535 : int'(prob);
  endfunction

  function automatic verdict_t classify(bit [15:0] rd);
    verdict_t v;
    longint unsigned n, p;
    int unsigned best;
    n = reading_cnt;
    for (int i = 0; i < 4; i++) begin
      p = tail_prob(rd, class_mean[i], inv_sigma);
      class_avg[i] = int'((n * class_avg[i] + p + ((n + 1) >> 1)) / (n + 1));
    end
    if (reading_cnt < 65535) reading_cnt++;
    best = class_avg[0];
    v.best_cls = '0;
    for (int i = 1; i < 4; i++) begin
      if (class_avg[i] > best) begin
        best = class_avg[i];
        v.best_cls = 2'(i);
      end
    end
    v.decided = (best >= threshold);
    if (v.decided) latched_cls = {1'b0, v.best_cls};
    v.best_prob = best[15:0];
    v.latched = latched_cls;
    return v;
  endfunction

  // register file model
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        class_mean[i] <= mean_reset(i);
        class_avg[i] = 0;
      end
      inv_sigma <= INV_SIGMA_RESET;
      threshold <= THRESHOLD_RESET;
      reading_cnt = 0;
      latched_cls = 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < REG_INV_SIGMA) class_mean[cfg_index[1:0]] <= cfg_data;
      else if (cfg_index == REG_INV_SIGMA) inv_sigma <= cfg_data;
      else if (cfg_index == REG_THRESHOLD) threshold <= cfg_data;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_peak_reading <= '0;
      in_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) verdict_q.push_back(classify(in_peak_reading));
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (reading_q.size() > 0) begin
        in_peak_reading <= reading_q.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: stalls and checks
  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 11);
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          v = verdict_q.pop_front();
          if (out_decided !== v.decided) begin
            $error("decided: expected %0d actual %0d", v.decided, out_decided);
            errors++;
          end
          if (out_best_class !== v.best_cls) begin
            $error("best_class: expected %0d actual %0d", v.best_cls, out_best_class);
            errors++;
          end
          if (out_best_probability !== v.best_prob) begin
            $error("best_probability: expected %0d actual %0d", v.best_prob,
                   out_best_probability);
            errors++;
          end
          if (out_latched_class !== v.latched) begin
            $error("latched_class: expected %0d actual %0d", v.latched, out_latched_class);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (reading_q.size() > 0 || in_valid || verdict_q.size() > 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // runs of readings clustered around one class, with some full-range noise
  task automatic queue_readings(int count);
    int cls, run, r;
    while (count > 0) begin
      cls = $urandom_range(0, 3);
      run = $urandom_range(3, 30);
      for (int j = 0; j < run && count > 0; j++, count--) begin
        case ($urandom_range(0, 9))
          0, 1:    reading_q.push_back(16'($urandom));
          2:       reading_q.push_back(class_mean[cls]);
          default: begin
            r = int'(class_mean[cls]) + $urandom_range(0, 1200) - 600;
            if (r < 0) r = 0;
            if (r > 65535) r = 65535;
            reading_q.push_back(16'(r));
          end
        endcase
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    quiet = 1'b0;
    cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, exact means, near and far tails
    reading_q.push_back(16'd0);
    reading_q.push_back(16'hFFFF);
    for (int i = 0; i < 4; i++) begin
      reading_q.push_back(class_mean[i]);
      reading_q.push_back(class_mean[i] + 16'd1);
      reading_q.push_back(class_mean[i] - 16'd300);
    end
    for (int i = 0; i < 6; i++) reading_q.push_back(class_mean[0]);
    wait_idle();

    // extreme settings, threshold zero
    write_reg(REG_MEAN0, 16'd0);
    write_reg(REG_MEAN0 + 3'd1, 16'hFFFF);
    write_reg(REG_MEAN0 + 3'd2, 16'h8000);
    write_reg(REG_MEAN0 + 3'd3, 16'd1);
    write_reg(REG_INV_SIGMA, 16'hFFFF);
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(3'd6, 16'h1234);
    write_reg(3'd7, 16'hFFFF);
    @(posedge clk);
    reading_q.push_back(16'd0);
    reading_q.push_back(16'hFFFF);
    queue_readings(120);
    wait_idle();

    // zero inverse sigma, full threshold
    for (int i = 0; i < 4; i++) write_reg(REG_MEAN0 + CFG_IDX_W'(i), 16'($urandom));
    write_reg(REG_INV_SIGMA, 16'd0);
    write_reg(REG_THRESHOLD, 16'hFFFF);
    @(posedge clk);
    queue_readings(80);
    wait_idle();

    // realistic spread
    for (int i = 0; i < 4; i++) begin
      write_reg(REG_MEAN0 + CFG_IDX_W'(i), 16'($urandom_range(4000, 20000)));
    end
    write_reg(REG_INV_SIGMA, 16'($urandom_range(2000, 30000)));
    write_reg(REG_THRESHOLD, 16'($urandom_range(20000, 60000)));
    @(posedge clk);
    queue_readings(250);
    wait_idle();

    for (int i = 0; i < 4; i++) write_reg(REG_MEAN0 + CFG_IDX_W'(i), mean_reset(i));
    write_reg(REG_INV_SIGMA, INV_SIGMA_RESET);
    write_reg(REG_THRESHOLD, THRESHOLD_RESET);
    @(posedge clk);
    queue_readings(120);
    wait_idle();

    quiet = 1'b1;
    queue_readings(110);
    wait_idle();
    repeat (700) @(posedge clk);

    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
